// File: src/brainfuck_program_executor_unit_assert.svh
// Assertion macros for the brainfuck program executor checker.
// Used by bfpe_checker.sv; depends on a clk and rst in the including scope.
`ifndef BRAINFUCK_PROGRAM_EXECUTOR_UNIT_ASSERT_SVH
`define BRAINFUCK_PROGRAM_EXECUTOR_UNIT_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define BFPE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bfpe assertion failed");

// Property checked on every clock edge, reset included.
`define BFPE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("bfpe assertion failed during reset");

`endif

// File: src/bfpe_pkg.sv
// Shared types, codes and character constants of the brainfuck program executor.
// No dependencies; used by the top-level module of the block and by its checker.
package bfpe_pkg;

  // Default storage sizes.
  localparam int CODE_DEPTH_DEF = 4096;
  localparam int TAPE_DEPTH_DEF = 512;

  // Command codes held in the code store.
  typedef enum logic [2:0] {
    CMD_INC   = 3'd0,
    CMD_DEC   = 3'd1,
    CMD_RIGHT = 3'd2,
    CMD_LEFT  = 3'd3,
    CMD_OPEN  = 3'd4,
    CMD_CLOSE = 3'd5,
    CMD_OUT   = 3'd6,
    CMD_NONE  = 3'd7
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DONE  = 2'd1,
    ST_UNMAT = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Request kinds carried in the input tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Source characters of interest.
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Map a source byte to its command code.
  function automatic cmd_t classify(input logic [7:0] ch);
    cmd_t c;
    unique case (ch)
      CH_PLUS:  c = CMD_INC;
      CH_MINUS: c = CMD_DEC;
      CH_GT:    c = CMD_RIGHT;
      CH_LT:    c = CMD_LEFT;
      CH_LBRK:  c = CMD_OPEN;
      CH_RBRK:  c = CMD_CLOSE;
      CH_DOT:   c = CMD_OUT;
      default:  c = CMD_NONE;
    endcase
    return c;
  endfunction

endpackage

// File: src/bfpe_tape.sv
// Byte tape of the brainfuck program executor with a clearing pass after reset.
// Depends on no package; instantiated by brainfuck_program_executor_unit.
module bfpe_tape #(
  parameter int TAPE_DEPTH = 512,
  localparam int TA_W = $clog2(TAPE_DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [TA_W-1:0] rd_addr,
  output logic [7:0]      rd_data,
  input  logic            wr_en,
  input  logic [TA_W-1:0] wr_addr,
  input  logic [7:0]      wr_data,
  output logic            busy
);

  logic [7:0]      mem [TAPE_DEPTH];
  logic [TA_W-1:0] clr_idx;

  // Sweep every cell to zero once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      if (clr_idx == TA_W'(TAPE_DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Single write port shared by the sweep and the executor; registered read.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= 8'd0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/brainfuck_program_executor_unit.sv
// Load request: the result is handed from S_RESP to the output register. Step request:
// the command is executed in S_EXEC; a taken bracket scans the code store entry by entry
// through S_SCAN and S_SCHK over its single read port, failing if a forward scan runs off
// the end of the program. A request holds the block until its result is handed to the
// output register; a new one is taken while the previous result waits. Reset is synchronous;
// a tape clearing pass over every cell follows, during which no request is accepted.
module brainfuck_program_executor_unit #(
  parameter int CODE_DEPTH = bfpe_pkg::CODE_DEPTH_DEF,
  parameter int TAPE_DEPTH = bfpe_pkg::TAPE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] source_char
  input  logic [0:0]  s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_char, [9:8] status, [15:10] zero
  output logic [0:0]  m_tuser    // [0] char_valid
);

  localparam int CLEN_W = $clog2(CODE_DEPTH + 1);
  localparam int CA_W   = $clog2(CODE_DEPTH);
  localparam int TA_W   = $clog2(TAPE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SCAN = 5'b00100,
    S_SCHK = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t            state;
  logic [CLEN_W-1:0] code_length;
  logic [CLEN_W-1:0] pc;
  logic [TA_W-1:0]   head;
  logic              in_comment;
  logic              error_halt;
  logic [CLEN_W-1:0] scan_idx;
  logic [CLEN_W-1:0] scan_depth;
  logic              scan_fwd;
  logic              res_valid;
  logic [7:0]        res_char;
  bfpe_pkg::status_t res_status;

  bfpe_pkg::cmd_t    code_mem [CODE_DEPTH];
  bfpe_pkg::cmd_t    code_q;
  logic [CA_W-1:0]   code_raddr;
  logic              code_we;
  bfpe_pkg::cmd_t    load_cmd;
  logic              load_keep;
  logic              load_full;

  logic [7:0]        tape_q;
  logic              tape_we;
  logic [7:0]        tape_wdata;
  logic              tape_busy;

  logic              accept;
  logic              out_free;
  logic              scan_match;
  logic              scan_nest;
  logic              open_jump;
  logic              close_jump;

  assign s_tready = (state == S_IDLE) && !tape_busy;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Decode of an incoming source byte and the store write it causes.
  assign load_cmd  = bfpe_pkg::classify(s_tdata);
  assign load_keep = accept && (s_tuser[0] == bfpe_pkg::OP_LOAD) && !in_comment &&
                     (s_tdata != bfpe_pkg::CH_HASH) && (load_cmd != bfpe_pkg::CMD_NONE);
  assign code_we   = load_keep && (code_length < CLEN_W'(CODE_DEPTH));
  assign load_full = load_keep && (code_length >= CLEN_W'(CODE_DEPTH));

  // The code store port follows the program counter when idle, the scan pointer otherwise.
  assign code_raddr = (state == S_IDLE) ? pc[CA_W-1:0] : scan_idx[CA_W-1:0];

  // Code store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (code_we) begin
      code_mem[code_length[CA_W-1:0]] <= load_cmd;
    end
    code_q <= code_mem[code_raddr];
  end

  // Cell update for + and -.
  assign tape_we    = (state == S_EXEC) &&
                      ((code_q == bfpe_pkg::CMD_INC) || (code_q == bfpe_pkg::CMD_DEC));
  assign tape_wdata = (code_q == bfpe_pkg::CMD_INC) ? tape_q + 8'd1 : tape_q - 8'd1;

  bfpe_tape #(
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_tape (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (head),
    .rd_data (tape_q),
    .wr_en   (tape_we),
    .wr_addr (head),
    .wr_data (tape_wdata),
    .busy    (tape_busy)
  );

  // Bracket classes seen by the scan, relative to its direction.
  assign scan_match = scan_fwd ? (code_q == bfpe_pkg::CMD_CLOSE) : (code_q == bfpe_pkg::CMD_OPEN);
  assign scan_nest  = scan_fwd ? (code_q == bfpe_pkg::CMD_OPEN) : (code_q == bfpe_pkg::CMD_CLOSE);

  // Brackets whose jump is taken on the current cell.
  assign open_jump  = (code_q == bfpe_pkg::CMD_OPEN) && (tape_q == 8'd0);
  assign close_jump = (code_q == bfpe_pkg::CMD_CLOSE) && (tape_q != 8'd0);

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      code_length <= '0;
      pc          <= '0;
      head        <= TA_W'(TAPE_DEPTH / 2);
      in_comment  <= 1'b0;
      error_halt  <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // Output valid rises when a result is handed over and falls once it is taken.
      if ((state == S_RESP) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_valid <= 1'b0;
            res_char  <= 8'd0;
            if (s_tuser[0] == bfpe_pkg::OP_LOAD) begin
              // Comment filter and append to the code store.
              state      <= S_RESP;
              res_status <= load_full ? bfpe_pkg::ST_FULL : bfpe_pkg::ST_OK;
              if (in_comment) begin
                if (s_tdata == bfpe_pkg::CH_NL) begin
                  in_comment <= 1'b0;
                end
              end else if (s_tdata == bfpe_pkg::CH_HASH) begin
                in_comment <= 1'b1;
              end
              if (code_we) begin
                code_length <= code_length + 1'b1;
              end
            end else if (error_halt) begin
              state      <= S_RESP;
              res_status <= bfpe_pkg::ST_UNMAT;
            end else if (pc >= code_length) begin
              state      <= S_RESP;
              res_status <= bfpe_pkg::ST_DONE;
            end else begin
              // Command and current cell are read this cycle.
              state      <= S_EXEC;
              res_status <= bfpe_pkg::ST_OK;
            end
          end
        end
        S_EXEC: begin
          if (open_jump) begin
            scan_fwd   <= 1'b1;
            scan_idx   <= pc + 1'b1;
            scan_depth <= '0;
            state      <= S_SCAN;
          end else if (close_jump && (pc == '0)) begin
            // Nothing lies before the first command.
            error_halt <= 1'b1;
            res_status <= bfpe_pkg::ST_UNMAT;
            state      <= S_RESP;
          end else if (close_jump) begin
            scan_fwd   <= 1'b0;
            scan_idx   <= pc - 1'b1;
            scan_depth <= '0;
            state      <= S_SCAN;
          end else begin
            pc    <= pc + 1'b1;
            state <= S_RESP;
          end
          case (code_q)
            bfpe_pkg::CMD_RIGHT: begin
              head <= (head == TA_W'(TAPE_DEPTH - 1)) ? '0 : head + 1'b1;
            end
            bfpe_pkg::CMD_LEFT: begin
              head <= (head == '0) ? TA_W'(TAPE_DEPTH - 1) : head - 1'b1;
            end
            bfpe_pkg::CMD_OUT: begin
              res_valid <= 1'b1;
              res_char  <= tape_q;
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          // A forward scan that runs past the program fails.
          if (scan_fwd && (scan_idx >= code_length)) begin
            error_halt <= 1'b1;
            res_status <= bfpe_pkg::ST_UNMAT;
            state      <= S_RESP;
          end else begin
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (scan_match && (scan_depth == '0)) begin
            pc    <= scan_idx + 1'b1;
            state <= S_RESP;
          end else begin
            if (scan_nest) begin
              scan_depth <= scan_depth + 1'b1;
            end else if (scan_match) begin
              scan_depth <= scan_depth - 1'b1;
            end
            if (scan_fwd) begin
              scan_idx <= scan_idx + 1'b1;
              state    <= S_SCAN;
            end else if (scan_idx == '0) begin
              error_halt <= 1'b1;
              res_status <= bfpe_pkg::ST_UNMAT;
              state      <= S_RESP;
            end else begin
              scan_idx <= scan_idx - 1'b1;
              state    <= S_SCAN;
            end
          end
        end
        S_RESP: begin
          // Hand the result to the output register once it is free.
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if ((state == S_RESP) && out_free) begin
      m_tdata <= {6'd0, res_status, res_char};
      m_tuser <= res_valid;
    end
  end

endmodule

// File: src/bfpe_checker.sv
// Port-level checker for the brainfuck program executor, bound to the top level.
// Depends on bfpe_pkg and brainfuck_program_executor_unit_assert.svh.
`include "brainfuck_program_executor_unit_assert.svh"

module bfpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser
);

  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // Requests accepted whose results have not been taken yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 2'd1;
    end
  end

  // Every result answers an earlier request, and at most two are in flight.
  `BFPE_ASSERT(a_no_spurious_result, out_acc |-> (pending != 2'd0))
  `BFPE_ASSERT(a_bounded_backlog, in_acc |-> (pending != 2'd2))
  // An emitted character always comes with an ok status; otherwise the byte is zero.
  `BFPE_ASSERT(a_char_status, (m_tvalid && m_tuser[0]) |-> (m_tdata[9:8] == bfpe_pkg::ST_OK))
  `BFPE_ASSERT(a_quiet_char, (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'd0))
  // The tape clearing pass blocks requests right after reset.
  `BFPE_ASSERT_RST(a_clear_after_reset, rst |=> !s_tready)

endmodule

bind brainfuck_program_executor_unit bfpe_checker u_bfpe_checker (.*);
